/* rtl/tcfr_pkg.sv */
// Shared constants and types for the text command frame receiver.
`default_nettype none

package tcfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W = 8;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned FRAME_BUFFER_BYTES_DEFAULT = 250;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h58;
  localparam logic [BYTE_W-1:0] LEN_OFFSET = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [POS_W-1:0] FIRST_DATA_POS = 8'd4;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd240;

  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0] store_pos;
    logic [BYTE_W-1:0] store_byte;
    logic [BYTE_W-1:0] frame_index;
    logic [BYTE_W-1:0] frame_command;
    logic [BYTE_W-1:0] payload_len;
  } result_t;

endpackage

`default_nettype wire

/* rtl/text_command_frame_receiver.sv */
// Top level of the text command frame receiver: byte parser with input and result registers.
`default_nettype none

// Takes one received byte per item and returns one result item per byte: ignored, store
// the byte at a frame position, frame complete (index, command, payload length) or frame
// dropped. The consumer keeps the payload bytes; this block holds only the header bytes
// and the position counter. Each byte goes from the input register to the result
// register, and a new byte can be taken every cycle while out_ready takes each result;
// the parse of a byte is a short compare and increment on the position counter. A
// result held by a low out_ready stalls the input register. max_payload is written through
// the cfg channel, which is always ready, and should only change while no byte is in flight.
module text_command_frame_receiver
  import tcfr_pkg::*;
#(
  parameter int unsigned FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BYTE_W-1:0]   rx_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [POS_W-1:0]         store_pos,
  output logic [BYTE_W-1:0]        store_byte,
  output logic [BYTE_W-1:0]        frame_index,
  output logic [BYTE_W-1:0]        frame_command,
  output logic [BYTE_W-1:0]        payload_len,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [BYTE_W-1:0]   max_payload
);

  localparam logic [POS_W-1:0] LAST_DATA_POS = POS_W'(FRAME_BUFFER_BYTES - 1);

  logic                in_full;
  logic [BYTE_W-1:0]   in_byte;
  logic                advance;

  logic [BYTE_W-1:0]   max_len;
  logic [POS_W-1:0]    frame_position;
  logic [POS_W-1:0]    frame_position_next;
  logic [BYTE_W-1:0]   held_index;
  logic [BYTE_W-1:0]   held_command;
  logic [BYTE_W-1:0]   held_length_byte;

  result_t             result;
  result_t             result_next;

  logic                is_term;
  logic [BYTE_W-1:0]   decl_len;
  logic [POS_W:0]      expect_pos;

  assign cfg_ready = 1'b1;
  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  assign is_term = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
  assign decl_len = held_length_byte - LEN_OFFSET;
  assign expect_pos = {1'b0, decl_len} + {1'b0, FIRST_DATA_POS} + (POS_W+1)'(1);

  always_comb begin
    result_next = '0;
    frame_position_next = frame_position;
    if (frame_position == '0) begin
      if (in_byte == START_BYTE) begin
        result_next.status = STATUS_STORED;
        result_next.store_byte = in_byte;
        frame_position_next = POS_W'(1);
      end else begin
        result_next.status = STATUS_IGNORED;
      end
    end else if (is_term) begin
      frame_position_next = '0;
      if (frame_position < FIRST_DATA_POS || decl_len > max_len ||
          (decl_len != '0 && {1'b0, frame_position} != expect_pos)) begin
        result_next.status = STATUS_DROPPED;
      end else begin
        result_next.status = STATUS_COMPLETE;
        result_next.frame_index = held_index;
        result_next.frame_command = held_command;
        // A terminator right after the length byte means an empty payload.
        if (frame_position > FIRST_DATA_POS) begin
          result_next.payload_len = frame_position - FIRST_DATA_POS - POS_W'(1);
        end
      end
    end else if (in_byte < LEN_OFFSET || frame_position >= LAST_DATA_POS) begin
      result_next.status = STATUS_DROPPED;
      frame_position_next = '0;
    end else begin
      result_next.status = STATUS_STORED;
      result_next.store_pos = frame_position;
      result_next.store_byte = in_byte;
      frame_position_next = frame_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      out_valid <= 1'b0;
      max_len <= MAX_PAYLOAD_RESET;
      frame_position <= '0;
      held_index <= '0;
      held_command <= '0;
      held_length_byte <= '0;
    end else begin
      if (cfg_valid) begin
        max_len <= max_payload;
      end
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        frame_position <= frame_position_next;
        if (!is_term && in_byte >= LEN_OFFSET && frame_position < LAST_DATA_POS) begin
          if (frame_position == POS_W'(1)) begin
            held_index <= in_byte;
          end
          if (frame_position == POS_W'(2)) begin
            held_command <= in_byte;
          end
          if (frame_position == POS_W'(3)) begin
            held_length_byte <= in_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign status = result.status;
  assign store_pos = result.store_pos;
  assign store_byte = result.store_byte;
  assign frame_index = result.frame_index;
  assign frame_command = result.frame_command;
  assign payload_len = result.payload_len;

  a_position_in_buffer: assert property (@(posedge clk) disable iff (rst)
    frame_position < POS_W'(FRAME_BUFFER_BYTES))
    else $error("frame position beyond the frame buffer");

  a_header_fields_only_on_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_COMPLETE |->
      frame_index == '0 && frame_command == '0 && payload_len == '0)
    else $error("frame fields set on a result that is not a completed frame");

  a_start_stored_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_STORED && store_pos == '0 |-> store_byte == START_BYTE)
    else $error("byte stored at position zero is not the start byte");

  a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    advance && (result_next.status == STATUS_COMPLETE ||
                result_next.status == STATUS_DROPPED) |=> frame_position == '0)
    else $error("frame end did not return the parser to hunting");

  a_payload_fits_buffer: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_COMPLETE |->
      payload_len <= LAST_DATA_POS - FIRST_DATA_POS - POS_W'(1))
    else $error("completed payload longer than the frame buffer allows");

endmodule

`default_nettype wire
